>>> hdl/dpp_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// Holds the beat structs, register indexes and colour-mode codes.
// No dependencies.
package dpp_pkg;

  // Pixel coordinate bits that take part in the projection.
  localparam int COORD_BITS = 12;

  localparam int COL_W = 12;
  localparam int DEPTH_W = 16;
  localparam int CENTER_W = 16;
  localparam int SCALE_W = 32;
  localparam int UNIT_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Coordinate bits actually present on the 12-bit port.
  localparam int COORD_EFF = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;

  // Offset magnitude |coord*16 - center| and the products that follow.
  localparam int MAG_W = 16;
  localparam int PROD1_W = MAG_W + DEPTH_W;
  localparam int PROD2_W = PROD1_W + SCALE_W;
  localparam int ZPROD_W = DEPTH_W + UNIT_W;
  localparam int XY_FRAC_DROP = 28;
  localparam int Z_FRAC_DROP = 16;
  localparam int RND_W = PROD2_W + 1 - XY_FRAC_DROP;

  localparam logic [UNIT_W-1:0] DEPTH_UNIT_RST = 32'd4294967;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MODE = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_SCALE_X    = 3'd3,
    REG_SCALE_Y    = 3'd4,
    REG_DEPTH_UNIT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    COLOR_RGB  = 2'd0,
    COLOR_BGR  = 2'd1,
    COLOR_MONO = 2'd2
  } color_mode_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [COL_W-1:0]   row;
    logic [DEPTH_W-1:0] depth_sample;
    logic [7:0]         pixel_byte0;
    logic [7:0]         pixel_byte1;
    logic [7:0]         pixel_byte2;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_z;
    logic               point_valid;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

>>> hdl/depth_pixel_to_point_top.sv
// Depth pixel back-projection through a pinhole camera model, with colour reorder.
// Five-stage multiply pipeline with per-stage valid bits and configuration registers.
// Depends on dpp_pkg.
//
// Use: one pixel beat per clock, while in_ready is high, enters on in_valid/in_ready
// (column, row, depth sample and three colour bytes) and leaves as one point beat on
// out_valid/out_ready (x, y, z in fixed point, a valid flag and RGB bytes).
// Configuration registers are written on cfg_valid/cfg_ready with an index
// and data; cfg_ready is always high. Write them only while the pipe is empty.
// out_valid rises once the beat has passed the registers of stages 1 to 5;
// throughput is one beat per cycle while out_ready stays high,
// set by the two chained 16x16 and 32x32 multipliers each having a stage of
// their own. A zero depth sample gives an invalid point with x, y and z zero.
// Reset (synchronous, rst_n low) empties the pipe and loads register
// defaults (rgb order, centers and scales zero, depth unit one millimeter).
// When out_ready is low the last beat holds in place; each stage takes a new beat
// only if it is empty or its successor moves, so bubbles close up and the
// input stalls only once all five stages are full.
module depth_pixel_to_point_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dpp_pkg::pixel_t                in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dpp_pkg::point_t                out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = 5;

  // configuration registers
  logic [1:0]                     color_mode_r;
  logic [dpp_pkg::CENTER_W-1:0]   center_x_r;
  logic [dpp_pkg::CENTER_W-1:0]   center_y_r;
  logic [dpp_pkg::SCALE_W-1:0]    scale_x_r;
  logic [dpp_pkg::SCALE_W-1:0]    scale_y_r;
  logic [dpp_pkg::UNIT_W-1:0]     depth_unit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= dpp_pkg::COLOR_RGB;
      center_x_r   <= '0;
      center_y_r   <= '0;
      scale_x_r    <= '0;
      scale_y_r    <= '0;
      depth_unit_r <= dpp_pkg::DEPTH_UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dpp_pkg::reg_idx_t'(cfg_index))
        dpp_pkg::REG_COLOR_MODE: color_mode_r <= cfg_data[1:0];
        dpp_pkg::REG_CENTER_X:   center_x_r   <= cfg_data[dpp_pkg::CENTER_W-1:0];
        dpp_pkg::REG_CENTER_Y:   center_y_r   <= cfg_data[dpp_pkg::CENTER_W-1:0];
        dpp_pkg::REG_SCALE_X:    scale_x_r    <= cfg_data[dpp_pkg::SCALE_W-1:0];
        dpp_pkg::REG_SCALE_Y:    scale_y_r    <= cfg_data[dpp_pkg::SCALE_W-1:0];
        dpp_pkg::REG_DEPTH_UNIT: depth_unit_r <= cfg_data[dpp_pkg::UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage moves when empty or when its successor moves
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: offsets from the principal point, colour reorder
  logic [16:0]                  cx16, cy16;
  logic [17:0]                  dx, dy;
  dpp_pkg::rgb_t                rgb_nxt;
  logic [dpp_pkg::MAG_W-1:0]    mag_x1_r, mag_y1_r;
  logic                         neg_x1_r, neg_y1_r, nz1_r;
  logic [dpp_pkg::DEPTH_W-1:0]  dep1_r;
  dpp_pkg::rgb_t                rgb1_r;

  always_comb begin
    cx16 = 17'({in_data.column[dpp_pkg::COORD_EFF-1:0], 4'b0000});
    cy16 = 17'({in_data.row[dpp_pkg::COORD_EFF-1:0], 4'b0000});
    dx = {1'b0, cx16} - {2'b00, center_x_r};
    dy = {1'b0, cy16} - {2'b00, center_y_r};
    case (dpp_pkg::color_mode_t'(color_mode_r))
      dpp_pkg::COLOR_BGR: rgb_nxt = '{in_data.pixel_byte2, in_data.pixel_byte1,
                                      in_data.pixel_byte0};
      dpp_pkg::COLOR_MONO: rgb_nxt = '{in_data.pixel_byte0, in_data.pixel_byte0,
                                       in_data.pixel_byte0};
      default: rgb_nxt = '{in_data.pixel_byte0, in_data.pixel_byte1,
                           in_data.pixel_byte2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      neg_x1_r <= dx[17];
      neg_y1_r <= dy[17];
      mag_x1_r <= dpp_pkg::MAG_W'(dx[17] ? (18'd0 - dx) : dx);
      mag_y1_r <= dpp_pkg::MAG_W'(dy[17] ? (18'd0 - dy) : dy);
      dep1_r   <= in_data.depth_sample;
      nz1_r    <= (in_data.depth_sample != '0);
      rgb1_r   <= rgb_nxt;
    end
  end

  // stage 2: offset times depth, depth times unit
  logic [dpp_pkg::PROD1_W-1:0]  px2_r, py2_r;
  logic [dpp_pkg::ZPROD_W-1:0]  z2_r;
  logic                         neg_x2_r, neg_y2_r, nz2_r;
  dpp_pkg::rgb_t                rgb2_r;

  always_ff @(posedge clk) begin
    if (adv[1] && v_r[0]) begin
      px2_r    <= dpp_pkg::PROD1_W'(mag_x1_r) * dpp_pkg::PROD1_W'(dep1_r);
      py2_r    <= dpp_pkg::PROD1_W'(mag_y1_r) * dpp_pkg::PROD1_W'(dep1_r);
      z2_r     <= dpp_pkg::ZPROD_W'(dep1_r) * dpp_pkg::ZPROD_W'(depth_unit_r);
      neg_x2_r <= neg_x1_r;
      neg_y2_r <= neg_y1_r;
      nz2_r    <= nz1_r;
      rgb2_r   <= rgb1_r;
    end
  end

  // stage 3: times the axis scale; round z to 16 fraction bits
  logic [dpp_pkg::PROD2_W-1:0]  qx3_r, qy3_r;
  logic [dpp_pkg::ZPROD_W:0]    z_rnd;
  logic [31:0]                  z3_r;
  logic                         neg_x3_r, neg_y3_r, nz3_r;
  dpp_pkg::rgb_t                rgb3_r;

  assign z_rnd = {1'b0, z2_r} + (dpp_pkg::ZPROD_W+1)'(1 << (dpp_pkg::Z_FRAC_DROP - 1));

  always_ff @(posedge clk) begin
    if (adv[2] && v_r[1]) begin
      qx3_r    <= dpp_pkg::PROD2_W'(px2_r) * dpp_pkg::PROD2_W'(scale_x_r);
      qy3_r    <= dpp_pkg::PROD2_W'(py2_r) * dpp_pkg::PROD2_W'(scale_y_r);
      z3_r     <= z_rnd[dpp_pkg::Z_FRAC_DROP +: 32];
      neg_x3_r <= neg_x2_r;
      neg_y3_r <= neg_y2_r;
      nz3_r    <= nz2_r;
      rgb3_r   <= rgb2_r;
    end
  end

  // stage 4: round to 16 fraction bits and clamp the magnitude
  logic [dpp_pkg::PROD2_W:0]    x_sum, y_sum;
  logic [dpp_pkg::RND_W-1:0]    rx, ry;
  logic [31:0]                  mx_nxt, my_nxt;
  logic [31:0]                  mx4_r, my4_r, z4_r;
  logic                         neg_x4_r, neg_y4_r, nz4_r;
  dpp_pkg::rgb_t                rgb4_r;

  always_comb begin
    x_sum = {1'b0, qx3_r} + (dpp_pkg::PROD2_W+1)'(1 << (dpp_pkg::XY_FRAC_DROP - 1));
    y_sum = {1'b0, qy3_r} + (dpp_pkg::PROD2_W+1)'(1 << (dpp_pkg::XY_FRAC_DROP - 1));
    rx = x_sum[dpp_pkg::PROD2_W:dpp_pkg::XY_FRAC_DROP];
    ry = y_sum[dpp_pkg::PROD2_W:dpp_pkg::XY_FRAC_DROP];
    // negative side reaches 2^31, positive side stops at 2^31-1
    if (neg_x3_r) mx_nxt = (rx > dpp_pkg::RND_W'(32'h8000_0000)) ? 32'h8000_0000 : rx[31:0];
    else          mx_nxt = (rx > dpp_pkg::RND_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rx[31:0];
    if (neg_y3_r) my_nxt = (ry > dpp_pkg::RND_W'(32'h8000_0000)) ? 32'h8000_0000 : ry[31:0];
    else          my_nxt = (ry > dpp_pkg::RND_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : ry[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3] && v_r[2]) begin
      mx4_r    <= mx_nxt;
      my4_r    <= my_nxt;
      z4_r     <= z3_r;
      neg_x4_r <= neg_x3_r;
      neg_y4_r <= neg_y3_r;
      nz4_r    <= nz3_r;
      rgb4_r   <= rgb3_r;
    end
  end

  // stage 5: apply sign, drop coordinates of zero-depth pixels
  dpp_pkg::point_t pt5_r;
  dpp_pkg::point_t pt_nxt;

  always_comb begin
    pt_nxt.point_x     = nz4_r ? (neg_x4_r ? (32'd0 - mx4_r) : mx4_r) : '0;
    pt_nxt.point_y     = nz4_r ? (neg_y4_r ? (32'd0 - my4_r) : my4_r) : '0;
    pt_nxt.point_z     = nz4_r ? z4_r : '0;
    pt_nxt.point_valid = nz4_r;
    pt_nxt.red         = rgb4_r.red;
    pt_nxt.green       = rgb4_r.green;
    pt_nxt.blue        = rgb4_r.blue;
  end

  always_ff @(posedge clk) begin
    if (adv[4] && v_r[3]) begin
      pt5_r <= pt_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_data  = pt5_r;

  // an invalid point never carries coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.point_valid) |->
      (out_data.point_x == 0 && out_data.point_y == 0 && out_data.point_z == 0))
    else $error("invalid point with nonzero coordinates");

  // input stalls only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (v_r == '0))
    else $error("pipe not empty after reset");

  // a held output beat keeps the pipe behind it from draining into it
  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(pt5_r)))
    else $error("stalled output beat changed");

endmodule

>>> sim/dpp_point_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the depth pixel back-projection block: watches the pixel, point and
// register channels, predicts each point and compares it field by field.
// Depends on dpp_pkg.
module dpp_point_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  dpp_pkg::pixel_t                in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  dpp_pkg::point_t                out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    points_pending,
  output int unsigned                    error_count
);

  localparam int unsigned PRINT_CAP = 40;

  // Shadow copy of the camera registers.
  dpp_pkg::color_mode_t           mode_q;
  logic [dpp_pkg::CENTER_W-1:0]   center_x_q;
  logic [dpp_pkg::CENTER_W-1:0]   center_y_q;
  logic [dpp_pkg::SCALE_W-1:0]    scale_x_q;
  logic [dpp_pkg::SCALE_W-1:0]    scale_y_q;
  logic [dpp_pkg::UNIT_W-1:0]     depth_unit_q;

  dpp_pkg::point_t expected_points[$];
  int unsigned     points_seen;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
    else if (error_count == PRINT_CAP + 1)
      $display("[%0t] further mismatches counted but not shown", $realtime);
  endtask

  // Signed Q15.16 of (coord*16 - center) * depth * scale / 2^44, rounded away from zero.
  function automatic logic [31:0] back_project(
    input logic [dpp_pkg::COL_W-1:0]    coord,
    input logic [dpp_pkg::CENTER_W-1:0] center,
    input logic [dpp_pkg::DEPTH_W-1:0]  depth,
    input logic [dpp_pkg::SCALE_W-1:0]  scale);
    logic [15:0] c16;
    logic        neg;
    logic [15:0] mag;
    logic [64:0] prod;
    logic [64:0] rnd;
    logic [31:0] sat;
    c16  = (16'(coord) & 16'((1 << dpp_pkg::COORD_BITS) - 1)) << 4;
    neg  = c16 < center;
    mag  = neg ? (center - c16) : (c16 - center);
    prod = 65'(mag) * 65'(depth) * 65'(scale);
    rnd  = (prod + (65'd1 << 27)) >> 28;
    if (neg) begin
      sat = (rnd > 65'h8000_0000) ? 32'h8000_0000 : rnd[31:0];
      return 32'd0 - sat;
    end
    return (rnd > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
  endfunction

  function automatic dpp_pkg::point_t predict_point(input dpp_pkg::pixel_t px);
    dpp_pkg::point_t pt;
    logic [48:0]     zprod;
    logic [32:0]     zrnd;
    pt = '0;
    if (px.depth_sample != '0) begin
      zprod = 49'(px.depth_sample) * 49'(depth_unit_q) + (49'd1 << 15);
      zrnd  = zprod[48:16];
      pt.point_z     = zrnd[32] ? 32'hFFFF_FFFF : zrnd[31:0];
      pt.point_x     = back_project(px.column, center_x_q, px.depth_sample, scale_x_q);
      pt.point_y     = back_project(px.row, center_y_q, px.depth_sample, scale_y_q);
      pt.point_valid = 1'b1;
    end
    case (mode_q)
      dpp_pkg::COLOR_BGR: begin
        pt.red   = px.pixel_byte2;
        pt.green = px.pixel_byte1;
        pt.blue  = px.pixel_byte0;
      end
      dpp_pkg::COLOR_MONO: begin
        pt.red   = px.pixel_byte0;
        pt.green = px.pixel_byte0;
        pt.blue  = px.pixel_byte0;
      end
      default: begin
        pt.red   = px.pixel_byte0;
        pt.green = px.pixel_byte1;
        pt.blue  = px.pixel_byte2;
      end
    endcase
    return pt;
  endfunction

  always @(posedge clk) begin
    dpp_pkg::point_t want;
    if (!rst_n) begin
      mode_q       <= dpp_pkg::COLOR_RGB;
      center_x_q   <= '0;
      center_y_q   <= '0;
      scale_x_q    <= '0;
      scale_y_q    <= '0;
      depth_unit_q <= dpp_pkg::DEPTH_UNIT_RST;
      expected_points.delete();
      points_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dpp_pkg::REG_COLOR_MODE: mode_q     <= dpp_pkg::color_mode_t'(cfg_data[1:0]);
          dpp_pkg::REG_CENTER_X:   center_x_q <= cfg_data[dpp_pkg::CENTER_W-1:0];
          dpp_pkg::REG_CENTER_Y:   center_y_q <= cfg_data[dpp_pkg::CENTER_W-1:0];
          dpp_pkg::REG_SCALE_X:    scale_x_q  <= cfg_data[dpp_pkg::SCALE_W-1:0];
          dpp_pkg::REG_SCALE_Y:    scale_y_q  <= cfg_data[dpp_pkg::SCALE_W-1:0];
          dpp_pkg::REG_DEPTH_UNIT: depth_unit_q <= cfg_data[dpp_pkg::UNIT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_error($sformatf("point beat with none expected: %h", out_data));
        end else begin
          want = expected_points.pop_front();
          if (out_data.point_x !== want.point_x)
            report_error($sformatf("point %0d x got %h want %h", points_seen,
                                   out_data.point_x, want.point_x));
          if (out_data.point_y !== want.point_y)
            report_error($sformatf("point %0d y got %h want %h", points_seen,
                                   out_data.point_y, want.point_y));
          if (out_data.point_z !== want.point_z)
            report_error($sformatf("point %0d z got %h want %h", points_seen,
                                   out_data.point_z, want.point_z));
          if (out_data.point_valid !== want.point_valid)
            report_error($sformatf("point %0d valid got %b want %b", points_seen,
                                   out_data.point_valid, want.point_valid));
          if (out_data.red !== want.red)
            report_error($sformatf("point %0d red got %h want %h", points_seen,
                                   out_data.red, want.red));
          if (out_data.green !== want.green)
            report_error($sformatf("point %0d green got %h want %h", points_seen,
                                   out_data.green, want.green));
          if (out_data.blue !== want.blue)
            report_error($sformatf("point %0d blue got %h want %h", points_seen,
                                   out_data.blue, want.blue));
        end
        points_seen++;
      end
      if (in_valid && in_ready)
        expected_points.push_back(predict_point(in_data));
      points_pending <= expected_points.size();
    end
  end

endmodule

>>> sim/depth_pixel_to_point_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for depth_pixel_to_point_top: drives pixel and register beats with random
// gaps and back-pressure, and gives the verdict. Depends on dpp_pkg and dpp_point_checker.
module depth_pixel_to_point_top_tb;

  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PHASE_PIXELS    = 245;
  localparam logic [dpp_pkg::CFG_IDX_W-1:0] REG_UNUSED6 = 3'd6;
  localparam logic [dpp_pkg::CFG_IDX_W-1:0] REG_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [dpp_pkg::CENTER_W-1:0] cx;
    logic [dpp_pkg::CENTER_W-1:0] cy;
    logic [dpp_pkg::SCALE_W-1:0]  sx;
    logic [dpp_pkg::SCALE_W-1:0]  sy;
    logic [dpp_pkg::UNIT_W-1:0]   unit;
  } camera_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  dpp_pkg::pixel_t                in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  dpp_pkg::point_t                out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dpp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned points_pending;
  int unsigned error_count;

  bit          tx_quiet     = 1'b0;
  bit          rx_quiet     = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned pixels_sent     = 0;
  int unsigned zero_depth_sent = 0;
  int unsigned settings_used   = 0;

  depth_pixel_to_point_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dpp_point_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .points_pending (points_pending),
    .error_count    (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic dpp_pkg::pixel_t mk_pixel(input int col, input int row, input int depth,
                                               input int b0, input int b1, input int b2);
    dpp_pkg::pixel_t px;
    px.column       = 12'(col);
    px.row          = 12'(row);
    px.depth_sample = 16'(depth);
    px.pixel_byte0  = 8'(b0);
    px.pixel_byte1  = 8'(b1);
    px.pixel_byte2  = 8'(b2);
    return px;
  endfunction

  function automatic dpp_pkg::pixel_t random_pixel();
    dpp_pkg::pixel_t px;
    px.column = 12'($urandom_range(0, 4095));
    px.row    = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0:       px.depth_sample = '0;
      1:       px.depth_sample = 16'hFFFF;
      2:       px.depth_sample = 16'($urandom_range(1, 255));
      default: px.depth_sample = 16'($urandom_range(0, 65535));
    endcase
    px.pixel_byte0 = 8'($urandom_range(0, 255));
    px.pixel_byte1 = 8'($urandom_range(0, 255));
    px.pixel_byte2 = 8'($urandom_range(0, 255));
    return px;
  endfunction

  // Spread values over all magnitudes, with the full-scale value now and then.
  function automatic logic [31:0] random_scale();
    if ($urandom_range(0, 5) == 0)
      return 32'hFFFF_FFFF;
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic logic [15:0] random_center();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(input logic [dpp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Call only with the pipe empty; upper data bits carry junk to check masking.
  task automatic apply_camera(input camera_t cam, input bit junk_writes);
    logic [31:0] r;
    r = $urandom();
    write_reg(dpp_pkg::REG_COLOR_MODE, {r[31:2], cam.mode});
    r = $urandom();
    write_reg(dpp_pkg::REG_CENTER_X, {r[31:16], cam.cx});
    r = $urandom();
    write_reg(dpp_pkg::REG_CENTER_Y, {r[31:16], cam.cy});
    write_reg(dpp_pkg::REG_SCALE_X, cam.sx);
    write_reg(dpp_pkg::REG_SCALE_Y, cam.sy);
    write_reg(dpp_pkg::REG_DEPTH_UNIT, cam.unit);
    if (junk_writes) begin
      write_reg(REG_UNUSED6, $urandom());
      write_reg(REG_UNUSED7, $urandom());
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input dpp_pkg::pixel_t px);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (px.depth_sample == '0)
      zero_depth_sent++;
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
  endtask

  // Receiver: random gap before each beat, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 10);
      if (hold_off_req) begin
        gap += HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d points outstanding",
             WATCHDOG_LIMIT, points_pending);
    $display("FAIL depth_pixel_to_point_top");
    $finish;
  end

  initial begin
    camera_t cam;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset.
    send_pixel(mk_pixel(100, 50, 1000, 8'h12, 8'h34, 8'h56));
    send_pixel(mk_pixel(0, 0, 0, 8'hFF, 8'h00, 8'hA5));
    drain_points();

    // Typical camera, bgr order.
    cam = '{2'(dpp_pkg::COLOR_BGR), 16'd5120, 16'd3840, 32'd1832519, 32'd1832519,
            dpp_pkg::DEPTH_UNIT_RST};
    apply_camera(cam, 1'b0);
    send_pixel(mk_pixel(0, 0, 65535, 8'h01, 8'h02, 8'h03));
    send_pixel(mk_pixel(4095, 4095, 65535, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(320, 240, 1000, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(319, 239, 1, 8'hAA, 8'h55, 8'hF0));
    send_pixel(mk_pixel(4095, 0, 0, 8'h0F, 8'hC3, 8'h3C));
    drain_points();

    // Every register but center y at full scale, mono: drive both saturation limits.
    cam = '{2'(dpp_pkg::COLOR_MONO), 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF};
    apply_camera(cam, 1'b0);
    send_pixel(mk_pixel(0, 4095, 65535, 8'h81, 8'h42, 8'h24));
    send_pixel(mk_pixel(4095, 0, 1, 8'h7E, 8'h00, 8'hFF));
    send_pixel(mk_pixel(4095, 4095, 65535, 8'hFF, 8'h11, 8'h22));
    send_pixel(mk_pixel(2048, 2048, 0, 8'h5A, 8'h33, 8'hCC));
    drain_points();

    // Unused colour code, zero x scale and unit, writes to unknown indexes.
    cam = '{2'd3, 16'h0000, 16'hFFFF, 32'd0, 32'd1, 32'd0};
    apply_camera(cam, 1'b1);
    send_pixel(mk_pixel(4095, 0, 65535, 8'h10, 8'h20, 8'h30));
    send_pixel(mk_pixel(1, 4095, 12345, 8'hFE, 8'hDC, 8'hBA));
    send_pixel(mk_pixel(0, 0, 0, 8'h00, 8'hFF, 8'h00));
    drain_points();

    // Exact halves: rounding goes away from zero on x and y, up on z.
    cam = '{2'(dpp_pkg::COLOR_RGB), 16'd15, 16'd15, 32'h0800_0000, 32'h0800_0000,
            32'h0000_8000};
    apply_camera(cam, 1'b0);
    send_pixel(mk_pixel(1, 0, 1, 8'h01, 8'h80, 8'hFE));
    send_pixel(mk_pixel(0, 1, 1, 8'h7F, 8'h01, 8'h80));
    send_pixel(mk_pixel(1, 1, 3, 8'h00, 8'h00, 8'h01));
    drain_points();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cam.mode = 2'($urandom_range(0, 3));
      cam.cx   = random_center();
      cam.cy   = random_center();
      cam.sx   = random_scale();
      cam.sy   = random_scale();
      cam.unit = random_scale();
      if (ph == RANDOM_PHASES - 1)
        cam = '{2'(dpp_pkg::COLOR_MONO), 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF};
      apply_camera(cam, ph % 3 == 0);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (n % 40 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        // Stall the output for a long stretch while pixels keep coming.
        if (ph == 1 && n == 100) begin
          tx_quiet     = 1'b1;
          hold_off_req = 1'b1;
        end
        send_pixel(random_pixel());
      end
      drain_points();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d pixels (%0d with no depth) under %0d camera settings,",
             pixels_sent, zero_depth_sent, settings_used);
    $display("with random gaps on both channels and one long output stall; %0d mismatches.",
             error_count);
    if (error_count == 0 && points_pending == 0)
      $display("PASS depth_pixel_to_point_top");
    else
      $display("FAIL depth_pixel_to_point_top");
    $finish;
  end

endmodule
